### rtl/vmks_pkg.sv
// Shared types and constants for the memory-kernel solve unit.
// No dependencies; imported by the stream interface users and the top level.
package vmks_pkg;

  typedef struct packed {
    logic signed [31:0] auto_corr;
    logic signed [31:0] cross_corr;
    logic signed [31:0] second_corr;
    logic               first_lag;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] kernel_value;
    logic [7:0]         lag_number;
    logic [1:0]         error_code;
  } out_item_t;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_ZERO_DIV = 2'd1;
  localparam logic [1:0] ERR_CAPACITY = 2'd2;

  localparam logic CFG_MASS = 1'b0;
  localparam logic CFG_STEP = 1'b1;

  localparam logic [63:0] SAT64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [46:0] SAT48 = 47'h7FFF_FFFF_FFFF;

  // partial products of one 64x64 multiply, and quotient bits of one division
  localparam int unsigned MUL_PARTS = 4;
  localparam int unsigned DIV_STEPS = 80;

endpackage

### rtl/vmks_stream_if.sv
// Valid/ready stream channel carrying one item per handshake.
// Payload type is a parameter; used with the types of vmks_pkg.
interface vmks_stream_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/volterra_memory_kernel_solve_unit.sv
// Memory-kernel solver: one input item per lag, one result item per input item.
// Time from acceptance to result valid grows with the lag; it is set by the single
// 32x32 multiplier (one 64-bit product per history term) and the one-bit-per-cycle
// divider. The next item can be taken in the cycle after the result is loaded.
// One item in flight at a time; a finished result waits in the output register.
// Reset (asynchronous, active low) clears control state; history RAMs are not cleared.
module volterra_memory_kernel_solve_unit
  import vmks_pkg::*;
#(
  parameter int unsigned MAX_LAGS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  vmks_stream_if.sink   in_i,
  vmks_stream_if.source out_o
);

  localparam int unsigned AW    = $clog2(MAX_LAGS);
  localparam int unsigned LAG_W = $clog2(MAX_LAGS + 1);
  localparam logic [LAG_W-1:0] LAG_MAX = LAG_W'(MAX_LAGS);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_FM2, S_FB, S_NMDT, S_NDEN, S_NA0, S_NACC0, S_LOOP,
    S_RDW, S_ADD, S_BC2, S_NUM, S_DIV, S_DFIN, S_WR, S_DONE
  } state_e;

  state_e state_q, ret_q;

  // configuration
  logic [31:0] mass_q, step_q;

  // current item
  logic signed [31:0] c0_q, c1_q, c2_q;

  // series state and working values
  logic [LAG_W-1:0]   lag_q;
  logic [AW-1:0]      idx_q, p_q;
  logic signed [63:0] base_q, den_q, acc_q, tmp_q;
  logic [47:0]        md_q;
  logic signed [47:0] s_q;
  logic [1:0]         err_q;

  // shared multiplier
  logic [63:0]  mul_a_q, mul_b_q, pp_q;
  logic [127:0] prod_q;
  logic [2:0]   mul_cnt_q;
  logic [1:0]   pp_k_q;
  logic         mul_neg_q, mul_sh17_q;

  // shared divider
  logic [63:0] rem_q;
  logic [79:0] dvd_q, quo_q;
  logic [63:0] dvs_q;
  logic [6:0]  div_cnt_q;
  logic        div_neg_q;

  // result
  out_item_t res_q, out_item_q;
  logic      out_valid_q;

  // history memories
  logic [31:0] ch_rdata;
  logic [47:0] kh_rdata;
  logic        ram_we;
  logic [AW-1:0] kh_raddr, ch_raddr;

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > $signed({1'b0, SAT64})) return $signed(SAT64);
    if (s < -$signed({1'b0, SAT64})) return -$signed(SAT64);
    return s[63:0];
  endfunction

  // multiplier: partial product select and shifted result
  logic [31:0]  pa, pb;
  logic [127:0] pp_shifted, mul_shifted;
  logic [63:0]  mul_mag;
  logic signed [63:0] mul_res;
  logic [1:0]   pp_k;
  logic [1:0]   pp_sum;

  assign pp_k   = mul_cnt_q[1:0];
  assign pa     = pp_k[1] ? mul_a_q[63:32] : mul_a_q[31:0];
  assign pb     = pp_k[0] ? mul_b_q[63:32] : mul_b_q[31:0];
  assign pp_sum = 2'(pp_k_q[1]) + 2'(pp_k_q[0]);
  assign pp_shifted  = {64'b0, pp_q} << {pp_sum, 5'b0};
  assign mul_shifted = mul_sh17_q ? (prod_q >> 17) : (prod_q >> 16);
  assign mul_mag     = (|mul_shifted[127:63]) ? SAT64 : {1'b0, mul_shifted[62:0]};
  assign mul_res     = mul_neg_q ? -$signed(mul_mag) : $signed(mul_mag);

  // divider step
  logic [64:0] div_r, div_rem_d;
  logic        div_ge;
  assign div_r     = {rem_q, dvd_q[79]};
  assign div_ge    = div_r >= {1'b0, dvs_q};
  assign div_rem_d = div_ge ? div_r - {1'b0, dvs_q} : div_r;

  logic [46:0] q_mag;
  assign q_mag = (|quo_q[79:47]) ? SAT48 : quo_q[46:0];

  // numerator, from the two products
  logic signed [63:0] num;
  assign num = add_sat(tmp_q, -mul_res);

  logic signed [47:0] kh_rdata_s;
  logic signed [63:0] kh_ext, ch_ext;
  assign kh_rdata_s = $signed(kh_rdata);
  assign kh_ext = 64'(kh_rdata_s);
  assign ch_ext = 64'($signed(ch_rdata));

  // output clamp and lag field
  logic signed [31:0] s_clamped;
  logic [LAG_W+7:0]   lag_wide, cap_wide;
  always_comb begin
    if (s_q > 48'sd2147483647)       s_clamped = 32'sh7FFF_FFFF;
    else if (s_q < -48'sd2147483648) s_clamped = 32'sh8000_0000;
    else                             s_clamped = s_q[31:0];
  end
  assign lag_wide = {8'b0, LAG_W'(idx_q)};
  assign cap_wide = {8'b0, LAG_MAX};

  logic [63:0] mdt;
  assign mdt = prod_q[63:0];

  logic in_fire;
  logic out_load;
  assign in_fire     = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;
  // load the finished result once the output register is free or being drained
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  assign ram_we   = (state_q == S_WR);
  assign kh_raddr = (state_q == S_LOOP) ? p_q : '0;
  assign ch_raddr = idx_q - p_q;

  vmks_ram #(.WIDTH(32), .DEPTH(MAX_LAGS)) u_cross_ram (
    .clk_i, .we_i(ram_we), .waddr_i(idx_q), .wdata_i(c1_q),
    .raddr_i(ch_raddr), .rdata_o(ch_rdata)
  );

  vmks_ram #(.WIDTH(48), .DEPTH(MAX_LAGS)) u_kernel_ram (
    .clk_i, .we_i(ram_we), .waddr_i(idx_q), .wdata_i(s_q),
    .raddr_i(kh_raddr), .rdata_o(kh_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      mass_q      <= 32'd65536;
      step_q      <= 32'd328;
      lag_q       <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
      mul_cnt_q   <= '0;
      div_cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MASS) mass_q <= cfg_data_i;
        else                       step_q <= cfg_data_i;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            c0_q <= in_i.data.auto_corr;
            c1_q <= in_i.data.cross_corr;
            c2_q <= in_i.data.second_corr;
            mul_cnt_q <= '0;
            prod_q    <= '0;
            mul_neg_q <= 1'b0;
            mul_a_q   <= {32'b0, mass_q};
            if (in_i.data.first_lag || lag_q == '0) begin
              // new series: m*m first
              mul_b_q <= {32'b0, mass_q};
              ret_q   <= S_FM2;
              state_q <= S_MUL;
            end else if (lag_q >= LAG_MAX) begin
              res_q.kernel_value <= '0;
              res_q.lag_number   <= cap_wide[7:0];
              res_q.error_code   <= ERR_CAPACITY;
              state_q            <= S_DONE;
            end else begin
              idx_q   <= lag_q[AW-1:0];
              mul_b_q <= {32'b0, step_q};
              ret_q   <= S_NMDT;
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          // one partial product a cycle, accumulate the previous one
          if (mul_cnt_q < 3'(MUL_PARTS)) begin
            pp_q   <= pa * pb;
            pp_k_q <= pp_k;
          end
          if (mul_cnt_q != '0) prod_q <= prod_q + pp_shifted;
          if (mul_cnt_q == 3'(MUL_PARTS)) state_q <= ret_q;
          mul_cnt_q <= mul_cnt_q + 3'd1;
        end
        S_FM2: begin
          mul_a_q    <= {16'b0, prod_q[63:16]};
          mul_b_q    <= mag64(64'(c0_q));
          mul_neg_q  <= c0_q[31];
          mul_sh17_q <= 1'b0;
          mul_cnt_q  <= '0;
          prod_q     <= '0;
          ret_q      <= S_FB;
          state_q    <= S_MUL;
        end
        S_FB: begin
          base_q <= mul_res;
          idx_q  <= '0;
          if (mul_res == '0) begin
            s_q   <= '0;
            err_q <= ERR_ZERO_DIV;
          end else begin
            s_q   <= 48'(c2_q);
            err_q <= ERR_OK;
          end
          state_q <= S_WR;
        end
        S_NMDT: begin
          md_q       <= mdt[63:16];
          mul_a_q    <= {17'b0, mdt[63:17]};
          mul_b_q    <= mag64(64'(c1_q));
          mul_neg_q  <= c1_q[31];
          mul_sh17_q <= 1'b0;
          mul_cnt_q  <= '0;
          prod_q     <= '0;
          ret_q      <= S_NDEN;
          state_q    <= S_MUL;
        end
        S_NDEN: begin
          // kernel lag 0 read is issued here
          den_q   <= add_sat(base_q, mul_res);
          state_q <= S_NA0;
        end
        S_NA0: begin
          mul_a_q    <= mag64(64'(c1_q));
          mul_b_q    <= mag64(kh_ext);
          mul_neg_q  <= c1_q[31] ^ kh_ext[63];
          mul_sh17_q <= 1'b1;
          mul_cnt_q  <= '0;
          prod_q     <= '0;
          ret_q      <= S_NACC0;
          state_q    <= S_MUL;
        end
        S_NACC0: begin
          acc_q   <= mul_res;
          p_q     <= AW'(1);
          state_q <= S_LOOP;
        end
        S_LOOP: begin
          if (p_q < idx_q) begin
            state_q <= S_RDW;
          end else begin
            mul_a_q    <= mag64(base_q);
            mul_b_q    <= mag64(64'(c2_q));
            mul_neg_q  <= base_q[63] ^ c2_q[31];
            mul_sh17_q <= 1'b0;
            mul_cnt_q  <= '0;
            prod_q     <= '0;
            ret_q      <= S_BC2;
            state_q    <= S_MUL;
          end
        end
        S_RDW: begin
          mul_a_q    <= mag64(ch_ext);
          mul_b_q    <= mag64(kh_ext);
          mul_neg_q  <= ch_ext[63] ^ kh_ext[63];
          mul_sh17_q <= 1'b0;
          mul_cnt_q  <= '0;
          prod_q     <= '0;
          ret_q      <= S_ADD;
          state_q    <= S_MUL;
        end
        S_ADD: begin
          acc_q   <= add_sat(acc_q, mul_res);
          p_q     <= p_q + AW'(1);
          state_q <= S_LOOP;
        end
        S_BC2: begin
          tmp_q      <= mul_res;
          mul_a_q    <= {16'b0, md_q};
          mul_b_q    <= mag64(acc_q);
          mul_neg_q  <= acc_q[63];
          mul_sh17_q <= 1'b0;
          mul_cnt_q  <= '0;
          prod_q     <= '0;
          ret_q      <= S_NUM;
          state_q    <= S_MUL;
        end
        S_NUM: begin
          if (den_q == '0) begin
            s_q     <= '0;
            err_q   <= ERR_ZERO_DIV;
            state_q <= S_WR;
          end else begin
            rem_q     <= '0;
            dvd_q     <= {mag64(num), 16'b0};
            quo_q     <= '0;
            dvs_q     <= mag64(den_q);
            div_neg_q <= num[63] ^ den_q[63];
            div_cnt_q <= '0;
            err_q     <= ERR_OK;
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q     <= div_rem_d[63:0];
          dvd_q     <= {dvd_q[78:0], 1'b0};
          quo_q     <= {quo_q[78:0], div_ge};
          div_cnt_q <= div_cnt_q + 7'd1;
          if (div_cnt_q == 7'(DIV_STEPS - 1)) state_q <= S_DFIN;
        end
        S_DFIN: begin
          s_q     <= div_neg_q ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
          state_q <= S_WR;
        end
        S_WR: begin
          // history written this cycle; advance the lag
          lag_q              <= LAG_W'(idx_q) + LAG_W'(1);
          res_q.kernel_value <= s_clamped;
          res_q.lag_number   <= lag_wide[7:0];
          res_q.error_code   <= err_q;
          state_q            <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_load) begin
            out_item_q <= res_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_err_code_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_item_q.error_code <= ERR_CAPACITY))
    else $error("reserved error code on output");

  a_lag_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lag_q <= LAG_MAX)
    else $error("lag counter beyond capacity");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (dvs_q != '0))
    else $error("division started with zero divisor");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("item accepted while previous still in work");

endmodule

### rtl/vmks_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vmks_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### tb/volterra_memory_kernel_solve_unit_test.sv
// Self-checking testbench for the memory-kernel solve unit: a directed table, then random series.
// Depends on vmks_pkg, vmks_stream_if and the volterra_memory_kernel_solve_unit top level.
module volterra_memory_kernel_solve_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vmks_pkg::*;

  localparam int unsigned LAG_DEPTH = 256;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned HOLD_OFF_CYCLES = 600;

  typedef struct {
    in_item_t  item;
    bit        known;
    out_item_t result;
  } table_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_idx;
  logic [31:0] cfg_data;

  vmks_stream_if #(.item_t(in_item_t))  corr_ch ();
  vmks_stream_if #(.item_t(out_item_t)) kernel_ch ();

  volterra_memory_kernel_solve_unit #(.MAX_LAGS(LAG_DEPTH)) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (corr_ch),
    .out_o      (kernel_ch)
  );

  // Shadow of the solver state, advanced on every accepted item within capacity.
  logic [31:0]        mass_q;
  logic [31:0]        step_q;
  logic signed [63:0] cross_hist [LAG_DEPTH];
  logic signed [63:0] kern_hist [LAG_DEPTH];
  logic signed [63:0] base_q;
  int unsigned        lag_cnt;

  out_item_t   pending_kernels [$];
  int unsigned mismatches;
  bit          no_gaps;     // phases with no idling on either side
  bit          hold_req;    // ask the receiver for one long hold-off

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // (a*b) >> sh on magnitudes, saturating to +-(2^63-1)
  function automatic logic signed [63:0] mul_q(logic signed [63:0] a, logic signed [63:0] b,
                                               int sh);
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [127:0] p;
    ma = a[63] ? (~a + 64'd1) : a;
    mb = b[63] ? (~b + 64'd1) : b;
    p = ({64'd0, ma} * {64'd0, mb}) >> sh;
    if (p > {64'd0, SAT64}) p = {64'd0, SAT64};
    return (a[63] ^ b[63]) ? -$signed(p[63:0]) : $signed(p[63:0]);
  endfunction

  function automatic logic signed [63:0] add_q(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > $signed({1'b0, SAT64})) return SAT64;
    if (s < -$signed({1'b0, SAT64})) return -$signed(SAT64);
    return s[63:0];
  endfunction

  // (n<<16)/d on magnitudes, saturating to +-(2^47-1)
  function automatic logic signed [63:0] div_q(logic signed [63:0] n, logic signed [63:0] d);
    logic [63:0]  un;
    logic [63:0]  ud;
    logic [127:0] q;
    un = n[63] ? (~n + 64'd1) : n;
    ud = d[63] ? (~d + 64'd1) : d;
    q = ({64'd0, un} << 16) / {64'd0, ud};
    if (q > {81'd0, SAT48}) q = {81'd0, SAT48};
    return (n[63] ^ d[63]) ? -$signed(q[63:0]) : $signed(q[63:0]);
  endfunction

  // Work out the kernel item for one lag and advance the shadow state.
  function automatic out_item_t solve_lag(in_item_t it);
    out_item_t          r;
    logic [63:0]        mdt;
    logic [63:0]        m2;
    logic signed [63:0] md;
    logic signed [63:0] h;
    logic signed [63:0] c1;
    logic signed [63:0] den;
    logic signed [63:0] acc;
    logic signed [63:0] num;
    logic signed [63:0] s;
    int unsigned        i;
    r = '0;
    s = 0;
    c1 = it.cross_corr;
    mdt = {32'd0, mass_q} * {32'd0, step_q};
    md = mdt >> 16;
    h = mdt >> 17;
    if (it.first_lag || lag_cnt == 0) begin
      i = 0;
      m2 = ({32'd0, mass_q} * {32'd0, mass_q}) >> 16;
      base_q = mul_q(m2, it.auto_corr, 16);
      if (base_q == 0) r.error_code = ERR_ZERO_DIV;
      else s = it.second_corr;
    end else if (lag_cnt >= LAG_DEPTH) begin
      // beyond capacity: nothing stored, state unchanged
      r.lag_number = LAG_DEPTH[7:0];
      r.error_code = ERR_CAPACITY;
      return r;
    end else begin
      i = lag_cnt;
      den = add_q(base_q, mul_q(h, c1, 16));
      acc = mul_q(c1, kern_hist[0], 17);
      for (int p = 1; p < i; p++) acc = add_q(acc, mul_q(cross_hist[i-p], kern_hist[p], 16));
      num = add_q(mul_q(base_q, it.second_corr, 16), -mul_q(md, acc, 16));
      if (den == 0) r.error_code = ERR_ZERO_DIV;
      else s = div_q(num, den);
    end
    cross_hist[i] = c1;
    kern_hist[i] = s;
    lag_cnt = i + 1;
    if (s > 64'sd2147483647) r.kernel_value = 32'h7FFF_FFFF;
    else if (s < -64'sd2147483648) r.kernel_value = 32'h8000_0000;
    else r.kernel_value = s[31:0];
    r.lag_number = i[7:0];
    return r;
  endfunction

  task automatic note_mismatch(string what, out_item_t exp_r, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected value %h lag %0d err %0d, got value %h lag %0d err %0d",
               $realtime, what, exp_r.kernel_value, exp_r.lag_number, exp_r.error_code,
               got.kernel_value, got.lag_number, got.error_code);
  endtask

  // Offer one item after a gap, then hold it until it is taken.
  task automatic send_item(in_item_t it, bit known, out_item_t typed);
    int unsigned gap;
    out_item_t   predicted;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk) corr_ch.valid = 1'b0;
    end
    @(negedge clk);
    corr_ch.valid = 1'b1;
    corr_ch.data = it;
    do @(posedge clk); while (!corr_ch.ready);
    predicted = solve_lag(it);
    pending_kernels.push_back(known ? typed : predicted);
  endtask

  // Drain: the sender waits until every expected item has come back.
  task automatic wait_drained();
    @(negedge clk) corr_ch.valid = 1'b0;
    while (pending_kernels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(logic [31:0] mass, logic [31:0] step);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = CFG_MASS;
    cfg_data = mass;
    @(negedge clk);
    cfg_idx = CFG_STEP;
    cfg_data = step;
    @(negedge clk);
    cfg_we = 1'b0;
    mass_q = mass;
    step_q = step;
  endtask

  function automatic logic [31:0] rand_corr(bit wide);
    logic [31:0] v;
    v = $urandom_range(0, 1 << 18);
    if (wide) return $urandom();
    return $urandom_range(0, 1) ? v : -v;
  endfunction

  // Receiver: random stalls, one long hold-off on request; check each item taken.
  initial begin
    int unsigned stall;
    out_item_t   got;
    out_item_t   exp_r;
    kernel_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 15);
      if (hold_req) begin
        stall = HOLD_OFF_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        @(negedge clk) kernel_ch.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) kernel_ch.ready = 1'b1;
      do @(posedge clk); while (!kernel_ch.valid);
      got = kernel_ch.data;
      if (pending_kernels.size() == 0) begin
        note_mismatch("unexpected item", '0, got);
      end else begin
        exp_r = pending_kernels.pop_front();
        if (got.kernel_value !== exp_r.kernel_value || got.lag_number !== exp_r.lag_number ||
            got.error_code !== exp_r.error_code)
          note_mismatch("kernel mismatch", exp_r, got);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((corr_ch.valid && corr_ch.ready) || (kernel_ch.valid && kernel_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("** volterra_memory_kernel_solve_unit: FAILED **");
        $finish;
      end
    end
  end

  // Stimulus: directed table, then random phases under changing register settings.
  initial begin
    table_row_t  dir_rows [$];
    table_row_t  row;
    in_item_t    it;
    logic [31:0] masses [4];
    logic [31:0] steps [4];
    int unsigned left;
    int unsigned len;
    bit          wide;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_MASS;
    cfg_data = '0;
    corr_ch.valid = 1'b0;
    corr_ch.data = '0;
    mismatches = 0;
    no_gaps = 1'b0;
    hold_req = 1'b0;
    mass_q = 32'd65536;
    step_q = 32'd328;
    base_q = 0;
    lag_cnt = 0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Rows at reset settings (m = 1.0, dt = 328, so h = 164 and B = C0).
    // Non-first item before any series: taken as lag 0, B = 0 gives a zero divisor.
    dir_rows.push_back('{'{32'sd0, 32'sd0, 32'sd0, 1'b0}, 1, '{32'sd0, 8'd0, ERR_ZERO_DIV}});
    // B still 0 and h*C1 truncates to 0: zero divisor at a later lag.
    dir_rows.push_back('{'{32'sd65536, 32'sd5, 32'sd7, 1'b0}, 1,
                         '{32'sd0, 8'd1, ERR_ZERO_DIV}});
    dir_rows.push_back('{'{32'sd65536, 32'sd0, 32'h7FFF_FFFF, 1'b1}, 1,
                         '{32'h7FFF_FFFF, 8'd0, ERR_OK}});
    dir_rows.push_back('{'{32'sd0, 32'h8000_0000, 32'h8000_0000, 1'b0}, 0, '0});
    dir_rows.push_back('{'{32'sd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0}, 0, '0});
    dir_rows.push_back('{'{32'h8000_0000, 32'sd0, 32'h8000_0000, 1'b1}, 1,
                         '{32'h8000_0000, 8'd0, ERR_OK}});
    dir_rows.push_back('{'{32'sd0, 32'sd12345, -32'sd999, 1'b0}, 0, '0});
    dir_rows.push_back('{'{32'sd0, 32'sd0, 32'sd5, 1'b1}, 1, '{32'sd0, 8'd0, ERR_ZERO_DIV}});
    dir_rows.push_back('{'{32'sd16400, 32'sd0, 32'sd65536, 1'b1}, 1,
                         '{32'sd65536, 8'd0, ERR_OK}});
    // Divisor cancels exactly: 16400 + (164 * -6553600) >> 16 = 0.
    dir_rows.push_back('{'{32'sd0, -32'sd6553600, 32'sd1, 1'b0}, 1,
                         '{32'sd0, 8'd1, ERR_ZERO_DIV}});
    dir_rows.push_back('{'{32'sd0, 32'sd65536, 32'sd65536, 1'b0}, 0, '0});
    dir_rows.push_back('{'{32'h7FFF_FFFF, -32'sd1, 32'sd0, 1'b0}, 0, '0});
    dir_rows.push_back('{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1}, 1,
                         '{32'h7FFF_FFFF, 8'd0, ERR_OK}});
    dir_rows.push_back('{'{32'sd0, -32'sd70000, 32'sd40000, 1'b0}, 0, '0});
    dir_rows.push_back('{'{32'sd0, 32'sd3000, -32'sd123456, 1'b0}, 0, '0});
    dir_rows.push_back('{'{32'sd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0}, 0, '0});
    dir_rows.push_back('{'{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1}, 0, '0});
    dir_rows.push_back('{'{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0}, 0, '0});
    foreach (dir_rows[k]) begin
      row = dir_rows[k];
      send_item(row.item, row.known, row.result);
    end
    wait_drained();

    // Register extremes, then random settings for the later phases.
    masses = '{32'd1, 32'hFFFF_FFFF, 32'd65536, 32'd65536};
    steps = '{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd328};
    for (int ph = 0; ph < 14; ph++) begin
      if (ph < 4) write_regs(masses[ph], steps[ph]);
      else if (ph % 2 == 0) write_regs($urandom_range(1, 32'hFFFF_FFFF), $urandom());
      else write_regs($urandom_range(16384, 262144), $urandom_range(0, 4096));
      no_gaps = (ph % 5 == 2);

      if (ph == 3) begin
        // One full series up to capacity and a few lags beyond it, small values.
        for (int k = 0; k < LAG_DEPTH + 6; k++) begin
          it.first_lag = (k == 0);
          it.auto_corr = $urandom_range(32768, 131072);
          it.cross_corr = rand_corr(0) >>> 4;
          it.second_corr = rand_corr(0);
          send_item(it, 0, '0);
        end
      end else begin
        left = 75;
        while (left > 0) begin
          len = $urandom_range(1, 24);
          if (len > left) len = left;
          wide = ($urandom_range(0, 9) < 2);
          for (int k = 0; k < len; k++) begin
            // Mostly well-formed series; some noise on first_lag and on the start.
            if ($urandom_range(0, 19) == 0) it.first_lag = $urandom_range(0, 1);
            else it.first_lag = (k == 0) && ($urandom_range(0, 15) != 0);
            it.auto_corr = wide ? $urandom() : rand_corr(0);
            it.cross_corr = rand_corr(wide || $urandom_range(0, 7) == 0);
            it.second_corr = rand_corr(wide || $urandom_range(0, 7) == 0);
            if (ph == 1 && left == 75 && k == 0) hold_req = 1'b1;
            send_item(it, 0, '0);
          end
          left -= len;
        end
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_kernels.size() == 0) begin
      $display("** volterra_memory_kernel_solve_unit: PASSED **");
    end else begin
      $display("** volterra_memory_kernel_solve_unit: FAILED **");
    end
    $finish;
  end

endmodule
